[design/wscd_pkg.sv]
`default_nettype none

package wscd_pkg;

    // Depth of the difference history. It must be a power of two, since the
    // ring position wraps naturally and division by the depth is a shift.
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);

    localparam int SAMPLE_W = 28;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SUM_W    = DIFF_W + HIST_IDX_W;
    localparam int FRAC_W   = 16;
    localparam int BASE_W   = SAMPLE_W + FRAC_W;

    localparam int QUIET_W  = 20;
    localparam int PLACED_W = 20;
    localparam int REMOVE_W = 21;
    localparam int COOL_W   = 8;
    localparam int GAIN_W   = 16;

    // Input queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_QUIET_BAND   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLACED_THR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REMOVED_THR  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_LEN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEAK_GAIN    = 3'd4;

    localparam logic [QUIET_W-1:0]         QUIET_RESET   = 20'd640;
    localparam logic [PLACED_W-1:0]        PLACED_RESET  = 20'd800;
    localparam logic signed [REMOVE_W-1:0] REMOVED_RESET = -21'sd1440;
    localparam logic [COOL_W-1:0]          COOL_RESET    = 8'd10;
    localparam logic [GAIN_W-1:0]          GAIN_RESET    = 16'd655;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PLACED  = 2'd1,
        EV_REMOVED = 2'd2
    } event_t;

    typedef struct packed {
        logic [QUIET_W-1:0]         quiet_band;
        logic [PLACED_W-1:0]        placed_threshold;
        logic signed [REMOVE_W-1:0] removed_threshold;
        logic [COOL_W-1:0]          cooldown_length;
        logic [GAIN_W-1:0]          leak_gain;
    } cfg_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
    } queue_head_t;

endpackage

`default_nettype wire

[design/wscd_front.sv]
`default_nettype none

module wscd_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [wscd_pkg::SAMPLE_W-1:0] weight_sample,
    input  wire logic                             pop,
    output wscd_pkg::queue_head_t                 head
);
    import wscd_pkg::*;

    logic signed [SAMPLE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic push, pull;

    // Stall comes from the fill count alone, so it never looks at in_valid.
    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pull     = pop && (count_reg != '0);

    assign head.valid  = (count_reg != '0);
    assign head.sample = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pull)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pull && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= weight_sample;
        end
    end

endmodule

`default_nettype wire

[design/wscd_back.sv]
`default_nettype none

module wscd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wscd_pkg::cfg_t        cfg,
    input  wire wscd_pkg::queue_head_t head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 change_event
);
    import wscd_pkg::*;

    localparam int CMP_W  = SUM_W + 2;
    localparam int PROD_W = GAIN_W + 1 + SUM_W;

    logic signed [BASE_W-1:0]   baseline_reg, baseline_next;
    logic signed [DIFF_W-1:0]   ring_reg [HIST_DEPTH];
    logic signed [DIFF_W-1:0]   ring_next [HIST_DEPTH];
    logic [HIST_IDX_W-1:0]      pos_reg, pos_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [COOL_W-1:0]          cool_reg, cool_next;
    logic                       out_valid_reg;
    event_t                     event_reg, event_next;

    logic                       fire;
    logic signed [SAMPLE_W-1:0] base_int;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   old_entry;
    logic signed [SUM_W-1:0]    sum_new;
    logic signed [CMP_W-1:0]    sum_cmp, quiet_lim, placed_lim, removed_lim;
    logic                       is_quiet, is_placed, is_removed;
    logic signed [PROD_W-1:0]   prod, leak;
    logic signed [PROD_W-1:0]   base_sum;
    logic signed [BASE_W-1:0]   base_leak;
    logic signed [BASE_W-1:0]   sample_q;

    // The output register takes a new result whenever it is empty or being drained.
    assign pop          = !out_valid_reg || !out_stall;
    assign fire         = pop && head.valid;
    assign out_valid    = out_valid_reg;
    assign change_event = event_reg;

    // Difference against the integer part of the baseline (floor of Q28.16).
    assign base_int  = baseline_reg[BASE_W-1:FRAC_W];
    assign diff      = {head.sample[SAMPLE_W-1], head.sample} - {base_int[SAMPLE_W-1], base_int};
    assign old_entry = ring_reg[pos_reg];
    assign sum_new   = sum_reg - {{HIST_IDX_W{old_entry[DIFF_W-1]}}, old_entry}
                               + {{HIST_IDX_W{diff[DIFF_W-1]}}, diff};

    // Thresholds scaled by the history depth.
    assign sum_cmp     = {{(CMP_W-SUM_W){sum_new[SUM_W-1]}}, sum_new};
    assign quiet_lim   = {{(CMP_W-QUIET_W-HIST_IDX_W){1'b0}}, cfg.quiet_band,
                          {HIST_IDX_W{1'b0}}};
    assign placed_lim  = {{(CMP_W-PLACED_W-HIST_IDX_W){1'b0}}, cfg.placed_threshold,
                          {HIST_IDX_W{1'b0}}};
    assign removed_lim = {{(CMP_W-REMOVE_W-HIST_IDX_W){cfg.removed_threshold[REMOVE_W-1]}},
                          cfg.removed_threshold, {HIST_IDX_W{1'b0}}};

    assign is_quiet   = (sum_cmp <= quiet_lim) && (sum_cmp >= -quiet_lim);
    assign is_placed  = (sum_cmp > placed_lim);
    assign is_removed = (sum_cmp < removed_lim);

    // Leak step: floor(gain * sum / depth), then saturate the new baseline.
    assign prod     = $signed({1'b0, cfg.leak_gain}) * sum_new;
    assign leak     = prod >>> HIST_IDX_W;
    assign base_sum = {{(PROD_W-BASE_W){baseline_reg[BASE_W-1]}}, baseline_reg} + leak;

    always_comb
    begin
        if (base_sum[PROD_W-1:BASE_W-1] == '0 || base_sum[PROD_W-1:BASE_W-1] == '1)
        begin
            base_leak = base_sum[BASE_W-1:0];
        end
        else if (base_sum[PROD_W-1])
        begin
            base_leak = {1'b1, {(BASE_W-1){1'b0}}};
        end
        else
        begin
            base_leak = {1'b0, {(BASE_W-1){1'b1}}};
        end
    end

    assign sample_q = {head.sample, {FRAC_W{1'b0}}};

    always_comb
    begin
        baseline_next = baseline_reg;
        ring_next     = ring_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        cool_next     = cool_reg;
        event_next    = EV_NONE;
        if (cool_reg != '0)
        begin
            cool_next     = cool_reg - 1'b1;
            baseline_next = sample_q;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                ring_next[i] = '0;
            end
            sum_next = '0;
        end
        else
        begin
            ring_next[pos_reg] = diff;
            pos_next           = pos_reg + 1'b1;
            sum_next           = sum_new;
            if (is_quiet)
            begin
                baseline_next = base_leak;
            end
            else if (is_placed || is_removed)
            begin
                baseline_next = sample_q;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    ring_next[i] = '0;
                end
                sum_next = '0;
                if (is_placed)
                begin
                    cool_next  = cfg.cooldown_length;
                    event_next = EV_PLACED;
                end
                else
                begin
                    event_next = EV_REMOVED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            cool_reg      <= '0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_NONE;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= head.valid;
            end
            if (fire)
            begin
                baseline_reg <= baseline_next;
                ring_reg     <= ring_next;
                pos_reg      <= pos_next;
                sum_reg      <= sum_next;
                cool_reg     <= cool_next;
                event_reg    <= event_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/weight_step_change_detector.sv]
// An accepted beat waits in the input queue; once popped, its result goes to the output register.
// Throughput: one beat per cycle while neither side stalls; the whole detector step (difference,
// ring sum, leak multiply) is done in the back end, which holds the only loop from one sample to
// the next. A two-beat input queue and the output register let either side stall without a
// bubble. Reset (rst_n, asynchronous, active low) clears baseline, ring, sum, cooldown and the
// queue, and loads the configuration registers with their defaults; no clearing pass is needed.
`default_nettype none

module weight_step_change_detector (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [wscd_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [wscd_pkg::DATA_W-1:0]           pwdata,
    output logic [wscd_pkg::DATA_W-1:0]                prdata,
    output logic                                       pready,
    // Sample channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [wscd_pkg::SAMPLE_W-1:0]  weight_sample,
    // Event channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [1:0]                                 change_event
);
    import wscd_pkg::*;

    logic [QUIET_W-1:0]         quiet_band_reg;
    logic [PLACED_W-1:0]        placed_thr_reg;
    logic signed [REMOVE_W-1:0] removed_thr_reg;
    logic [COOL_W-1:0]          cool_len_reg;
    logic [GAIN_W-1:0]          leak_gain_reg;

    logic                       cfg_write;
    logic [REG_IDX_W-1:0]       reg_idx;
    cfg_t                       cfg;
    queue_head_t                head;
    logic                       pop;

    // The port never inserts wait states. Registers sit on word addresses, so
    // the two low address bits take no part in the decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_band_reg  <= QUIET_RESET;
            placed_thr_reg  <= PLACED_RESET;
            removed_thr_reg <= REMOVED_RESET;
            cool_len_reg    <= COOL_RESET;
            leak_gain_reg   <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_QUIET_BAND:   quiet_band_reg  <= pwdata[QUIET_W-1:0];
                REG_PLACED_THR:   placed_thr_reg  <= pwdata[PLACED_W-1:0];
                REG_REMOVED_THR:  removed_thr_reg <= pwdata[REMOVE_W-1:0];
                REG_COOLDOWN_LEN: cool_len_reg    <= pwdata[COOL_W-1:0];
                REG_LEAK_GAIN:    leak_gain_reg   <= pwdata[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read data follows the address; the removal threshold reads back sign-extended.
    always_comb
    begin
        case (reg_idx)
            REG_QUIET_BAND:   prdata = {{(DATA_W-QUIET_W){1'b0}}, quiet_band_reg};
            REG_PLACED_THR:   prdata = {{(DATA_W-PLACED_W){1'b0}}, placed_thr_reg};
            REG_REMOVED_THR:  prdata = {{(DATA_W-REMOVE_W){removed_thr_reg[REMOVE_W-1]}},
                                        removed_thr_reg};
            REG_COOLDOWN_LEN: prdata = {{(DATA_W-COOL_W){1'b0}}, cool_len_reg};
            REG_LEAK_GAIN:    prdata = {{(DATA_W-GAIN_W){1'b0}}, leak_gain_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.quiet_band        = quiet_band_reg;
    assign cfg.placed_threshold  = placed_thr_reg;
    assign cfg.removed_threshold = removed_thr_reg;
    assign cfg.cooldown_length   = cool_len_reg;
    assign cfg.leak_gain         = leak_gain_reg;

    // The front end only buffers samples; all detector state lives in the back end.
    wscd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .weight_sample (weight_sample),
        .pop           (pop),
        .head          (head)
    );

    // The back end runs one detector step per popped beat and holds the
    // result in its output register until the consumer takes it.
    wscd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .change_event (change_event)
    );

endmodule

`default_nettype wire

[design/wscd_checker.sv]
`default_nettype none

module wscd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  change_event
);
    import wscd_pkg::*;

    // Beats accepted but not yet delivered: two in the queue, one at the output.
    logic [2:0] pending_reg, pending_next;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(change_event))
        else $error("event changed or vanished while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("event shown with no sample outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more samples outstanding than the buffering holds");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready
                              && paddr[4:2] == REG_COOLDOWN_LEN)
        && paddr == $past(paddr) |-> prdata == {24'd0, $past(pwdata[7:0])})
        else $error("cooldown length does not read back as written");

endmodule

bind weight_step_change_detector wscd_checker u_wscd_checker (.*);

`default_nettype wire
